// ===== hw/rtl/dsft_pkg.sv =====
// dsft_pkg: shared types, constants and helper functions for the dshot frame encoder
// no dependencies; used by dsft_ctrl, dsft_dp and the top level
package dsft_pkg;

	localparam int MOTORS_DEF      = 4;
	localparam int FRAME_BITS      = 16;
	localparam int SLOT_W          = 6;
	localparam int BIT_IDX_W       = 4;
	localparam int PHASE_W         = 2;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 32;
	localparam int MOTOR_W         = 2;
	localparam int THROTTLE_W      = 10;
	localparam int VALUE_W         = 11;
	localparam int SPAN_W          = 11;
	localparam int PROD_W          = THROTTLE_W + SPAN_W;
	localparam int IDLE_W          = 9;
	localparam int TIME_W          = 32;

	localparam logic [IDLE_W-1:0]     IDLE_RESET     = 9'd40;
	localparam logic [TIME_W-1:0]     CUT_US_RESET   = 32'd1000000;
	localparam logic [TIME_W-1:0]     FS_START_RESET = 32'd1;
	localparam logic [THROTTLE_W-1:0] THR_MAX        = 10'd1022;
	localparam logic [VALUE_W-1:0]    BASE_FWD       = 11'd48;
	localparam logic [VALUE_W-1:0]    BASE_REV       = 11'd1048;
	localparam logic [SPAN_W-1:0]     UNI_SPAN       = 11'd2001;
	localparam logic [SPAN_W-1:0]     BI_SPAN        = 11'd1000;
	localparam logic [PHASE_W-1:0]    PHASE_HIGH     = 2'd0;
	localparam logic [PHASE_W-1:0]    PHASE_DATA     = 2'd1;
	localparam logic [PHASE_W-1:0]    PHASE_LOW      = 2'd2;
	localparam logic [BIT_IDX_W-1:0]  BIT_LAST       = 4'd15;

	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_OFFSET   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BIDIRECTIONAL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FAILSAFE_CUT  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_DECIDE,
		ST_CUT,
		ST_EMIT
	} dsft_state_t;

	typedef struct packed {
		logic load_in;
		logic map;
		logic decide;
		logic merge;
		logic emit_cut;
		logic emit_slot;
	} dsft_cmd_t;

	typedef struct packed {
		logic motor_ok;
		logic is_last;
		logic cut_hit;
		logic out_free;
		logic slot_last;
	} dsft_sts_t;

	// 11-bit value, telemetry bit 0, xor-of-nibbles checksum
	function automatic logic [FRAME_BITS-1:0] build_frame(input logic [VALUE_W-1:0] value);
		logic [11:0] pkt;
		logic [3:0]  csum;
		pkt  = {value, 1'b0};
		csum = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];
		return {pkt, csum};
	endfunction

endpackage

// ===== hw/rtl/dshot_four_motor_frame_tx_core.sv =====
// dshot_four_motor_frame_tx_core: top level of the dshot frame encoder
// depends on dsft_pkg, dsft_ctrl and dsft_dp
//
// One motor command is taken at a time. A command for any motor but the last
// is captured, multiplied and merged into the store and gives no output.
// A command for the last motor takes the same steps and then streams 48 slot
// transfers, at most one a cycle, set by the output register and out_stall,
// after which the frame store is empty again. A failsafe cut gives one
// transfer with cut and last_slot high once the output register is free, and
// leaves the store untouched. Commands with a motor index at or above MOTORS
// are dropped. The next command is taken once the current one is finished;
// the last transfer may still sit in the output register at that time.
module dshot_four_motor_frame_tx_core #(
	parameter int MOTORS = dsft_pkg::MOTORS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dsft_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dsft_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [dsft_pkg::MOTOR_W-1:0]     motor,
	input  logic [dsft_pkg::THROTTLE_W-1:0]  throttle,
	input  logic                             on_ground,
	input  logic                             failsafe_active,
	input  logic [dsft_pkg::TIME_W-1:0]      time_us,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [MOTORS-1:0]                pin_levels,
	output logic                             cut,
	output logic                             last_slot
);

	dsft_pkg::dsft_cmd_t cmd;
	dsft_pkg::dsft_sts_t sts;

	dsft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsft_dp #(
		.MOTORS (MOTORS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.motor           (motor),
		.throttle        (throttle),
		.on_ground       (on_ground),
		.failsafe_active (failsafe_active),
		.time_us         (time_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pin_levels      (pin_levels),
		.cut             (cut),
		.last_slot       (last_slot),
		.cmd             (cmd),
		.sts             (sts)
	);

endmodule

// ===== hw/rtl/dsft_ctrl.sv =====
// dsft_ctrl: command sequencer for the dshot frame encoder
// depends on dsft_pkg; drives dsft_dp through dsft_cmd_t, reads dsft_sts_t
module dsft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dsft_pkg::dsft_sts_t sts,
	output dsft_pkg::dsft_cmd_t cmd
);

	dsft_pkg::dsft_state_t state_q;
	dsft_pkg::dsft_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			dsft_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = dsft_pkg::ST_MAP;
				end
			end
			dsft_pkg::ST_MAP: begin
				cmd.map = 1'b1;
				state_d = dsft_pkg::ST_DECIDE;
			end
			dsft_pkg::ST_DECIDE: begin
				if (!sts.motor_ok) begin
					state_d = dsft_pkg::ST_IDLE;
				end else begin
					cmd.decide = 1'b1;
					if (sts.cut_hit) begin
						state_d = dsft_pkg::ST_CUT;
					end else begin
						cmd.merge = 1'b1;
						state_d   = sts.is_last ? dsft_pkg::ST_EMIT : dsft_pkg::ST_IDLE;
					end
				end
			end
			dsft_pkg::ST_CUT: begin
				if (sts.out_free) begin
					cmd.emit_cut = 1'b1;
					state_d      = dsft_pkg::ST_IDLE;
				end
			end
			dsft_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_slot = 1'b1;
					if (sts.slot_last) begin
						state_d = dsft_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = dsft_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/dsft_dp.sv =====
// dsft_dp: config registers, throttle map, failsafe timer, frame store and output register
// depends on dsft_pkg; sequenced by dsft_ctrl
module dsft_dp #(
	parameter int MOTORS = dsft_pkg::MOTORS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dsft_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dsft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [dsft_pkg::MOTOR_W-1:0]         motor,
	input  logic [dsft_pkg::THROTTLE_W-1:0]      throttle,
	input  logic                                 on_ground,
	input  logic                                 failsafe_active,
	input  logic [dsft_pkg::TIME_W-1:0]          time_us,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [MOTORS-1:0]                    pin_levels,
	output logic                                 cut,
	output logic                                 last_slot,
	input  dsft_pkg::dsft_cmd_t                  cmd,
	output dsft_pkg::dsft_sts_t                  sts
);

	localparam int MCW = 4;

	// configuration
	logic [dsft_pkg::IDLE_W-1:0] idle_q;
	logic                        bidir_q;
	logic                        dir_q;
	logic [dsft_pkg::TIME_W-1:0] cut_us_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q   <= dsft_pkg::IDLE_RESET;
			bidir_q  <= 1'b0;
			dir_q    <= 1'b0;
			cut_us_q <= dsft_pkg::CUT_US_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dsft_pkg::REG_IDLE_OFFSET:   idle_q   <= cfg_wdata[dsft_pkg::IDLE_W-1:0];
				dsft_pkg::REG_BIDIRECTIONAL: bidir_q  <= cfg_wdata[0];
				dsft_pkg::REG_DIRECTION:     dir_q    <= cfg_wdata[0];
				dsft_pkg::REG_FAILSAFE_CUT:  cut_us_q <= cfg_wdata[dsft_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// input capture
	logic [dsft_pkg::MOTOR_W-1:0]    motor_q;
	logic [dsft_pkg::THROTTLE_W-1:0] thr_q;
	logic                            ground_q;
	logic                            fs_q;
	logic [dsft_pkg::TIME_W-1:0]     time_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			motor_q  <= motor;
			thr_q    <= (throttle > dsft_pkg::THR_MAX) ? dsft_pkg::THR_MAX : throttle;
			ground_q <= on_ground;
			fs_q     <= failsafe_active;
			time_q   <= time_us;
		end
	end

	// throttle map: product stage then sum
	logic [dsft_pkg::SPAN_W-1:0]  span;
	logic [dsft_pkg::VALUE_W-1:0] base;
	logic [dsft_pkg::PROD_W-1:0]  prod_q;
	logic [dsft_pkg::VALUE_W-1:0] base_q;

	always_comb begin
		if (bidir_q) begin
			span = dsft_pkg::BI_SPAN - dsft_pkg::SPAN_W'(idle_q);
			base = (dir_q ? dsft_pkg::BASE_REV : dsft_pkg::BASE_FWD)
				+ dsft_pkg::VALUE_W'(idle_q);
		end else begin
			span = dsft_pkg::UNI_SPAN - dsft_pkg::SPAN_W'({idle_q, 1'b0});
			base = dsft_pkg::BASE_FWD + dsft_pkg::VALUE_W'({idle_q, 1'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			prod_q <= dsft_pkg::PROD_W'(thr_q) * dsft_pkg::PROD_W'(span);
			base_q <= base;
		end
	end

	logic [dsft_pkg::VALUE_W-1:0]    value;
	logic [dsft_pkg::FRAME_BITS-1:0] frame;

	always_comb begin
		value = base_q + prod_q[dsft_pkg::PROD_W-1:dsft_pkg::THROTTLE_W];
		if (ground_q) begin
			value = '0;
		end
		frame = dsft_pkg::build_frame(value);
	end

	// failsafe timer
	logic [dsft_pkg::TIME_W-1:0] fs_start_q;
	logic [dsft_pkg::TIME_W-1:0] fs_elapsed;

	assign fs_elapsed = time_q - fs_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_start_q <= dsft_pkg::FS_START_RESET;
		end else if (cmd.decide) begin
			if (!fs_q) begin
				fs_start_q <= '0;
			end else if (fs_start_q == '0) begin
				fs_start_q <= time_q;
			end
		end
	end

	// frame store: slot 3i is the start pulse, 3i+1 the data bit, 3i+2 always low
	logic [MOTORS-1:0]                   written_q;
	logic [dsft_pkg::FRAME_BITS-1:0]     frame_q [MOTORS];
	logic [dsft_pkg::PHASE_W-1:0]        phase_q;
	logic [dsft_pkg::BIT_IDX_W-1:0]      bit_q;
	logic                                slot_last;
	logic [MOTORS-1:0]                   data_bits;

	assign slot_last = (bit_q == dsft_pkg::BIT_LAST) && (phase_q == dsft_pkg::PHASE_LOW);

	always_comb begin
		for (int m = 0; m < MOTORS; m++) begin
			data_bits[m] = frame_q[m][dsft_pkg::FRAME_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			phase_q   <= dsft_pkg::PHASE_HIGH;
			bit_q     <= '0;
			for (int m = 0; m < MOTORS; m++) begin
				frame_q[m] <= '0;
			end
		end else if (cmd.merge) begin
			for (int m = 0; m < MOTORS; m++) begin
				if (MCW'(motor_q) == MCW'(m)) begin
					written_q[m] <= 1'b1;
					frame_q[m]   <= frame_q[m] | frame;
				end
			end
		end else if (cmd.emit_slot) begin
			if (slot_last) begin
				written_q <= '0;
				phase_q   <= dsft_pkg::PHASE_HIGH;
				bit_q     <= '0;
				for (int m = 0; m < MOTORS; m++) begin
					frame_q[m] <= '0;
				end
			end else if (phase_q == dsft_pkg::PHASE_LOW) begin
				phase_q <= dsft_pkg::PHASE_HIGH;
				bit_q   <= bit_q + dsft_pkg::BIT_IDX_W'(1);
				for (int m = 0; m < MOTORS; m++) begin
					frame_q[m] <= {frame_q[m][dsft_pkg::FRAME_BITS-2:0], 1'b0};
				end
			end else begin
				phase_q <= phase_q + dsft_pkg::PHASE_W'(1);
			end
		end
	end

	// output register
	logic              out_valid_q;
	logic [MOTORS-1:0] pin_q;
	logic              cut_q;
	logic              last_q;
	logic              out_free;
	logic [MOTORS-1:0] slot_levels;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (phase_q)
			dsft_pkg::PHASE_HIGH: slot_levels = written_q;
			dsft_pkg::PHASE_DATA: slot_levels = data_bits;
			default:              slot_levels = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_cut || cmd.emit_slot) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_cut) begin
			pin_q  <= '0;
			cut_q  <= 1'b1;
			last_q <= 1'b1;
		end else if (cmd.emit_slot) begin
			pin_q  <= slot_levels;
			cut_q  <= 1'b0;
			last_q <= slot_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign pin_levels = pin_q;
	assign cut        = cut_q;
	assign last_slot  = last_q;

	always_comb begin
		sts.motor_ok  = MCW'(motor_q) < MCW'(MOTORS);
		sts.is_last   = MCW'(motor_q) == MCW'(MOTORS - 1);
		sts.cut_hit   = fs_q && (fs_start_q != '0) && (fs_elapsed > cut_us_q);
		sts.out_free  = out_free;
		sts.slot_last = slot_last;
	end

endmodule
